FILE: rtl/hrp_pkg.sv
// Shared widths and sideband types for the Hessian eigen ridge pixel block.
// No dependencies; used by the top level.
package hrp_pkg;

	localparam int DATA_W     = 20;
	localparam int T_W        = 21;
	localparam int MAG_W      = 21;
	localparam int SQ1_W      = 42;
	localparam int ROOT1_W    = 21;
	localparam int EIG2_W     = 23;
	localparam int MU_W       = 22;
	localparam int VY_W       = 24;
	localparam int AY_W       = 23;
	localparam int SQ2_W      = 48;
	localparam int ROOT2_W    = 24;
	localparam int NRM_FRAC   = 14;
	localparam int NRM_W      = 16;
	localparam int QUO_W      = 15;
	localparam int DIVIDEND_W = 38;
	localparam int RIDGE_W    = 21;

	typedef struct packed {
		logic signed [T_W-1:0]    t;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic                     flip;
	} eig_side_t;

	typedef struct packed {
		logic signed [MU_W-1:0] ml;
		logic signed [MU_W-1:0] ms;
		logic                   sx;
		logic                   sy;
		logic                   zero;
		logic                   an;
		logic                   flip;
	} nrm_side_t;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [AY_W-1:0]  ay;
		nrm_side_t        nrm;
	} hyp_side_t;

endpackage

FILE: rtl/hrp_sqrt_cell.sv
// One digit cell of a pipelined integer square root: two radicand bits per cell.
// Depends on nothing; chained by the top level.
module hrp_sqrt_cell #(
	parameter int RAD_W  = 42,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_i,
	input  logic [RAD_W-1:0]      rad_i,
	input  logic [RAD_W/2-1:0]    root_i,
	input  logic [RAD_W/2+1:0]    rem_i,
	input  logic [SIDE_W-1:0]     side_i,
	output logic                  v_q,
	output logic [RAD_W-1:0]      rad_q,
	output logic [RAD_W/2-1:0]    root_q,
	output logic [RAD_W/2+1:0]    rem_q,
	output logic [SIDE_W-1:0]     side_q
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	assign rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
	assign trial  = {root_i, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= rad_i << 2;
		root_q <= {root_i[ROOT_W-2:0], ge};
		rem_q  <= ge ? rem_sh - trial : rem_sh;
		side_q <= side_i;
	end

endmodule

FILE: rtl/hrp_div_cell.sv
// One quotient-bit cell of a pipelined restoring divider, two lanes on a shared divisor.
// Depends on nothing; chained by the top level.
module hrp_div_cell #(
	parameter int DEN_W  = 24,
	parameter int QB     = 15,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_i,
	input  logic [DEN_W-1:0]  den_i,
	input  logic [DEN_W-1:0]  remx_i,
	input  logic [DEN_W-1:0]  remy_i,
	input  logic [QB-1:0]     lowx_i,
	input  logic [QB-1:0]     lowy_i,
	input  logic [QB-1:0]     quox_i,
	input  logic [QB-1:0]     quoy_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              v_q,
	output logic [DEN_W-1:0]  den_q,
	output logic [DEN_W-1:0]  remx_q,
	output logic [DEN_W-1:0]  remy_q,
	output logic [QB-1:0]     lowx_q,
	output logic [QB-1:0]     lowy_q,
	output logic [QB-1:0]     quox_q,
	output logic [QB-1:0]     quoy_q,
	output logic [SIDE_W-1:0] side_q
);
	logic [DEN_W:0] shx, shy, dext, subx, suby;
	logic           gex, gey;

	assign shx  = {remx_i, lowx_i[QB-1]};
	assign shy  = {remy_i, lowy_i[QB-1]};
	assign dext = {1'b0, den_i};
	assign gex  = shx >= dext;
	assign gey  = shy >= dext;
	assign subx = gex ? shx - dext : shx;
	assign suby = gey ? shy - dext : shy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		den_q  <= den_i;
		remx_q <= subx[DEN_W-1:0];
		remy_q <= suby[DEN_W-1:0];
		lowx_q <= lowx_i << 1;
		lowy_q <= lowy_i << 1;
		quox_q <= {quox_i[QB-2:0], gex};
		quoy_q <= {quoy_i[QB-2:0], gey};
		side_q <= side_i;
	end

endmodule

FILE: rtl/hessian_eigen_ridge_pixel.sv
// Hessian eigen ridge pixel: eigenvalues, unit normal and ridge strength per pixel.
// One request per cycle, busy stays low; the path runs through two square-root
// cell chains (21 and 24 cells) and a 15-cell divider chain.
// Results leave on a one-cycle done strobe; the receiver cannot stall.
// Reset clears all valid bits and sets fix_normals to 1.
// Depends on hrp_pkg, hrp_sqrt_cell and hrp_div_cell.
module hessian_eigen_ridge_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic signed [19:0] hess_xx,
	input  logic signed [19:0] hess_yy,
	input  logic signed [19:0] hess_xy,
	input  logic signed [19:0] grad_x,
	input  logic signed [19:0] grad_y,
	output logic        done,
	output logic signed [21:0] mu_small,
	output logic signed [21:0] mu_large,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic [20:0] ridge_strength
);
	localparam int DW  = hrp_pkg::DATA_W;
	localparam int S1W = $bits(hrp_pkg::eig_side_t);
	localparam int S2W = $bits(hrp_pkg::hyp_side_t);
	localparam int S3W = $bits(hrp_pkg::nrm_side_t);
	localparam int R1W = hrp_pkg::ROOT1_W;
	localparam int R2W = hrp_pkg::ROOT2_W;
	localparam int QW  = hrp_pkg::QUO_W;

	logic fix_normals_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_normals_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			fix_normals_q <= cfg_data;
		end
	end

	// stage 1: sums, magnitudes, sign fix decision
	logic signed [hrp_pkg::T_W-1:0] diff, t_c, b2_c;
	logic [hrp_pkg::MAG_W-1:0] ad_c, b2m_c;
	logic flip_c;

	assign diff  = {hess_xx[DW-1], hess_xx} - {hess_yy[DW-1], hess_yy};
	assign t_c   = {hess_xx[DW-1], hess_xx} + {hess_yy[DW-1], hess_yy};
	assign b2_c  = {hess_xy, 1'b0};
	assign ad_c  = diff[hrp_pkg::T_W-1] ? ~diff + 1'b1 : diff;
	assign b2m_c = b2_c[hrp_pkg::T_W-1] ? ~b2_c + 1'b1 : b2_c;
	assign flip_c = fix_normals_q &&
		((!grad_y[DW-1] && grad_y != '0) || (grad_y == '0 && !grad_x[DW-1] && grad_x != '0));

	logic v_s1;
	logic [hrp_pkg::MAG_W-1:0] ad_s1, b2m_s1;
	hrp_pkg::eig_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ad_s1        <= ad_c;
		b2m_s1       <= b2m_c;
		side_s1.t    <= t_c;
		side_s1.a    <= hess_xx;
		side_s1.b    <= hess_xy;
		side_s1.flip <= flip_c;
	end

	// stage 2: squares
	logic v_s2;
	logic [hrp_pkg::SQ1_W-1:0] sqa_s2, sqb_s2;
	hrp_pkg::eig_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqa_s2  <= ad_s1 * ad_s1;
		sqb_s2  <= b2m_s1 * b2m_s1;
		side_s2 <= side_s1;
	end

	// first square-root chain: D
	logic                      c1_v    [0:R1W];
	logic [hrp_pkg::SQ1_W-1:0] c1_rad  [0:R1W];
	logic [R1W-1:0]            c1_root [0:R1W];
	logic [R1W+1:0]            c1_rem  [0:R1W];
	logic [S1W-1:0]            c1_side [0:R1W];

	assign c1_v[0]    = v_s2;
	assign c1_rad[0]  = sqa_s2 + sqb_s2;
	assign c1_root[0] = '0;
	assign c1_rem[0]  = '0;
	assign c1_side[0] = side_s2;

	for (genvar i = 0; i < R1W; i++) begin : g_sqrt1
		hrp_sqrt_cell #(.RAD_W(hrp_pkg::SQ1_W), .SIDE_W(S1W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(c1_v[i]), .rad_i(c1_rad[i]), .root_i(c1_root[i]),
			.rem_i(c1_rem[i]), .side_i(c1_side[i]),
			.v_q(c1_v[i+1]), .rad_q(c1_rad[i+1]), .root_q(c1_root[i+1]),
			.rem_q(c1_rem[i+1]), .side_q(c1_side[i+1])
		);
	end

	// stage 3: doubled eigenvalues, order by magnitude
	hrp_pkg::eig_side_t e_side;
	logic signed [hrp_pkg::EIG2_W-1:0] p2, m2;
	logic [hrp_pkg::EIG2_W-1:0] p2m, m2m;

	assign e_side = c1_side[R1W];
	assign p2  = {{2{e_side.t[hrp_pkg::T_W-1]}}, e_side.t} + {2'b00, c1_root[R1W]};
	assign m2  = {{2{e_side.t[hrp_pkg::T_W-1]}}, e_side.t} - {2'b00, c1_root[R1W]};
	assign p2m = p2[hrp_pkg::EIG2_W-1] ? ~p2 + 1'b1 : p2;
	assign m2m = m2[hrp_pkg::EIG2_W-1] ? ~m2 + 1'b1 : m2;

	logic v_s3, flip_s3;
	logic signed [hrp_pkg::EIG2_W-1:0] lg2_s3, sm2_s3;
	logic signed [DW-1:0] a_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= c1_v[R1W];
		end
	end

	always_ff @(posedge clk) begin
		lg2_s3  <= (p2m > m2m) ? p2 : m2;
		sm2_s3  <= (p2m > m2m) ? m2 : p2;
		a_s3    <= e_side.a;
		b_s3    <= e_side.b;
		flip_s3 <= e_side.flip;
	end

	// stage 4: direction vector
	logic signed [hrp_pkg::T_W-1:0]  vx_c;
	logic signed [hrp_pkg::VY_W-1:0] vy_c, vym_c;
	logic [hrp_pkg::MAG_W-1:0]       ax_c;

	assign vx_c  = {b_s3, 1'b0};
	assign vy_c  = {lg2_s3[hrp_pkg::EIG2_W-1], lg2_s3} - {{3{a_s3[DW-1]}}, a_s3, 1'b0};
	assign ax_c  = vx_c[hrp_pkg::T_W-1] ? ~vx_c + 1'b1 : vx_c;
	assign vym_c = vy_c[hrp_pkg::VY_W-1] ? ~vy_c + 1'b1 : vy_c;

	logic v_s4;
	logic [hrp_pkg::MAG_W-1:0] ax_s4;
	logic [hrp_pkg::AY_W-1:0]  ay_s4;
	hrp_pkg::nrm_side_t nrm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ax_s4       <= ax_c;
		ay_s4       <= vym_c[hrp_pkg::AY_W-1:0];
		nrm_s4.ml   <= lg2_s3[hrp_pkg::EIG2_W-1:1];
		nrm_s4.ms   <= sm2_s3[hrp_pkg::EIG2_W-1:1];
		nrm_s4.sx   <= b_s3[DW-1];
		nrm_s4.sy   <= vy_c[hrp_pkg::VY_W-1];
		nrm_s4.zero <= (b_s3 == '0) && (vy_c == '0);
		nrm_s4.an   <= a_s3[DW-1];
		nrm_s4.flip <= flip_s3;
	end

	// stage 5: squares of the vector
	logic v_s5;
	logic [2*hrp_pkg::MAG_W-1:0] ax2_s5;
	logic [2*hrp_pkg::AY_W-1:0]  ay2_s5;
	hrp_pkg::hyp_side_t hs_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ax2_s5    <= ax_s4 * ax_s4;
		ay2_s5    <= ay_s4 * ay_s4;
		hs_s5.ax  <= ax_s4;
		hs_s5.ay  <= ay_s4;
		hs_s5.nrm <= nrm_s4;
	end

	// second square-root chain: hypot
	logic                      c2_v    [0:R2W];
	logic [hrp_pkg::SQ2_W-1:0] c2_rad  [0:R2W];
	logic [R2W-1:0]            c2_root [0:R2W];
	logic [R2W+1:0]            c2_rem  [0:R2W];
	logic [S2W-1:0]            c2_side [0:R2W];

	assign c2_v[0]    = v_s5;
	assign c2_rad[0]  = {{(hrp_pkg::SQ2_W-2*hrp_pkg::MAG_W){1'b0}}, ax2_s5}
		+ {{(hrp_pkg::SQ2_W-2*hrp_pkg::AY_W){1'b0}}, ay2_s5};
	assign c2_root[0] = '0;
	assign c2_rem[0]  = '0;
	assign c2_side[0] = hs_s5;

	for (genvar i = 0; i < R2W; i++) begin : g_sqrt2
		hrp_sqrt_cell #(.RAD_W(hrp_pkg::SQ2_W), .SIDE_W(S2W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(c2_v[i]), .rad_i(c2_rad[i]), .root_i(c2_root[i]),
			.rem_i(c2_rem[i]), .side_i(c2_side[i]),
			.v_q(c2_v[i+1]), .rad_q(c2_rad[i+1]), .root_q(c2_root[i+1]),
			.rem_q(c2_rem[i+1]), .side_q(c2_side[i+1])
		);
	end

	// divider chain: rounded |v| * 2^14 / hypot
	hrp_pkg::hyp_side_t h_side;
	logic [R2W-1:0] hyp;
	logic [hrp_pkg::DIVIDEND_W-1:0] nx_c, ny_c, half_c;

	assign h_side = c2_side[R2W];
	assign hyp    = c2_root[R2W];
	assign half_c = {{(hrp_pkg::DIVIDEND_W-R2W+1){1'b0}}, hyp[R2W-1:1]};
	assign nx_c   = {{(hrp_pkg::DIVIDEND_W-hrp_pkg::MAG_W-hrp_pkg::NRM_FRAC){1'b0}},
		h_side.ax, {hrp_pkg::NRM_FRAC{1'b0}}} + half_c;
	assign ny_c   = {{(hrp_pkg::DIVIDEND_W-hrp_pkg::AY_W-hrp_pkg::NRM_FRAC){1'b0}},
		h_side.ay, {hrp_pkg::NRM_FRAC{1'b0}}} + half_c;

	logic           d_v    [0:QW];
	logic [R2W-1:0] d_den  [0:QW];
	logic [R2W-1:0] d_remx [0:QW];
	logic [R2W-1:0] d_remy [0:QW];
	logic [QW-1:0]  d_lowx [0:QW];
	logic [QW-1:0]  d_lowy [0:QW];
	logic [QW-1:0]  d_quox [0:QW];
	logic [QW-1:0]  d_quoy [0:QW];
	logic [S3W-1:0] d_side [0:QW];

	assign d_v[0]    = c2_v[R2W];
	assign d_den[0]  = hyp;
	assign d_remx[0] = {{(R2W-hrp_pkg::DIVIDEND_W+QW){1'b0}}, nx_c[hrp_pkg::DIVIDEND_W-1:QW]};
	assign d_remy[0] = {{(R2W-hrp_pkg::DIVIDEND_W+QW){1'b0}}, ny_c[hrp_pkg::DIVIDEND_W-1:QW]};
	assign d_lowx[0] = nx_c[QW-1:0];
	assign d_lowy[0] = ny_c[QW-1:0];
	assign d_quox[0] = '0;
	assign d_quoy[0] = '0;
	assign d_side[0] = h_side.nrm;

	for (genvar i = 0; i < QW; i++) begin : g_div
		hrp_div_cell #(.DEN_W(R2W), .QB(QW), .SIDE_W(S3W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(d_v[i]), .den_i(d_den[i]), .remx_i(d_remx[i]), .remy_i(d_remy[i]),
			.lowx_i(d_lowx[i]), .lowy_i(d_lowy[i]), .quox_i(d_quox[i]),
			.quoy_i(d_quoy[i]), .side_i(d_side[i]),
			.v_q(d_v[i+1]), .den_q(d_den[i+1]), .remx_q(d_remx[i+1]),
			.remy_q(d_remy[i+1]), .lowx_q(d_lowx[i+1]), .lowy_q(d_lowy[i+1]),
			.quox_q(d_quox[i+1]), .quoy_q(d_quoy[i+1]), .side_q(d_side[i+1])
		);
	end

	// stage 6: clamp, sign, flip, ridge strength
	localparam logic [QW-1:0] ONE_Q = QW'(1) << hrp_pkg::NRM_FRAC;

	hrp_pkg::nrm_side_t f_side;
	logic [QW-1:0] qx_c, qy_c;
	logic signed [hrp_pkg::NRM_W-1:0] nxs_c, nys_c, nxf_c, nyf_c;
	logic [hrp_pkg::MU_W-1:0] mlm_c, msm_c;
	logic signed [hrp_pkg::MU_W:0] rd_c;
	logic [hrp_pkg::RIDGE_W-1:0] ridge_c;

	assign f_side = d_side[QW];
	assign qx_c   = (d_quox[QW] > ONE_Q) ? ONE_Q : d_quox[QW];
	assign qy_c   = (d_quoy[QW] > ONE_Q) ? ONE_Q : d_quoy[QW];

	always_comb begin
		if (f_side.zero) begin
			nxs_c = f_side.an ? -$signed({1'b0, ONE_Q}) : $signed({1'b0, ONE_Q});
			nys_c = '0;
		end else begin
			nxs_c = f_side.sx ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
			nys_c = f_side.sy ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
		end
		nxf_c = f_side.flip ? -nxs_c : nxs_c;
		nyf_c = f_side.flip ? -nys_c : nys_c;
	end

	assign mlm_c = f_side.ml[hrp_pkg::MU_W-1] ? ~f_side.ml + 1'b1 : f_side.ml;
	assign msm_c = f_side.ms[hrp_pkg::MU_W-1] ? ~f_side.ms + 1'b1 : f_side.ms;
	assign rd_c  = $signed({1'b0, mlm_c}) - $signed({1'b0, msm_c});

	always_comb begin
		if ((!f_side.ml[hrp_pkg::MU_W-1] && f_side.ml != '0) || rd_c[hrp_pkg::MU_W]) begin
			ridge_c = '0;
		end else if (rd_c[hrp_pkg::MU_W-1]) begin
			ridge_c = '1;
		end else begin
			ridge_c = rd_c[hrp_pkg::RIDGE_W-1:0];
		end
	end

	logic done_q;
	logic signed [hrp_pkg::MU_W-1:0]  ms_q, ml_q;
	logic signed [hrp_pkg::NRM_W-1:0] nx_q, ny_q;
	logic [hrp_pkg::RIDGE_W-1:0]      ridge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		ms_q    <= f_side.ms;
		ml_q    <= f_side.ml;
		nx_q    <= nxf_c;
		ny_q    <= nyf_c;
		ridge_q <= ridge_c;
	end

	assign done           = done_q;
	assign mu_small       = ms_q;
	assign mu_large       = ml_q;
	assign normal_x       = nx_q;
	assign normal_y       = ny_q;
	assign ridge_strength = ridge_q;

	a_normal_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384))
		else $error("normal_x out of unit range");

	a_ridge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mu_large > 0) |-> (ridge_strength == '0))
		else $error("ridge strength nonzero for positive mu_large");

	a_request_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> v_s1)
		else $error("accepted request lost at stage 1");

	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(d_v[QW] && f_side.zero) |=> (normal_y == '0))
		else $error("zero direction gave nonzero normal_y");

endmodule

FILE: tb/tb_hessian_eigen_ridge_pixel.sv
// Testbench for hessian_eigen_ridge_pixel: drives pixel requests and fix_normals writes,
// predicts eigenvalues, normals and ridge strength in a scoreboard class, checks each done.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

class ridge_scoreboard;
	typedef struct {
		logic signed [21:0] ms;
		logic signed [21:0] ml;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [20:0]        rs;
	} pix_res_t;

	pix_res_t pending[$];
	int       mismatches;
	bit       fix_normals;

	function new();
		mismatches = 0;
		fix_normals = 1'b1;
	endfunction

	static function longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	static function longint unsigned mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	static function longint halve(longint v);
		if (v >= 0) return v / 2;
		return -longint'((mag(v) + 1) / 2);
	endfunction

	static function longint clip22(longint v);
		if (v > 2097151) return 2097151;
		if (v < -2097152) return -2097152;
		return v;
	endfunction

	function void note_request(logic signed [19:0] xx, yy, xy, gx, gy);
		longint a, d, b, t, dd, p2, m2, lg2, sm2, ml, ms, vx, vy, nx, ny, r;
		longint unsigned ad, b2, ax, ay, hyp, qx, qy;
		pix_res_t e;
		a = xx; d = yy; b = xy;
		t = a + d;
		ad = mag(a - d);
		b2 = mag(2 * b);
		dd = longint'(isqrt(ad * ad + b2 * b2));
		p2 = t + dd;
		m2 = t - dd;
		if (mag(p2) > mag(m2)) begin
			lg2 = p2; sm2 = m2;
		end else begin
			lg2 = m2; sm2 = p2;
		end
		ml = clip22(halve(lg2));
		ms = clip22(halve(sm2));
		vx = 2 * b;
		vy = lg2 - 2 * a;
		if (vx == 0 && vy == 0) begin
			nx = a < 0 ? -16384 : 16384;
			ny = 0;
		end else begin
			ax = mag(vx);
			ay = mag(vy);
			while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
				ax >>= 1;
				ay >>= 1;
			end
			hyp = isqrt(ax * ax + ay * ay);
			if (hyp == 0) hyp = 1;
			qx = ((ax << 14) + hyp / 2) / hyp;
			qy = ((ay << 14) + hyp / 2) / hyp;
			if (qx > 16384) qx = 16384;
			if (qy > 16384) qy = 16384;
			nx = vx < 0 ? -longint'(qx) : longint'(qx);
			ny = vy < 0 ? -longint'(qy) : longint'(qy);
		end
		if (fix_normals && (gy > 0 || (gy == 0 && gx > 0))) begin
			nx = -nx;
			ny = -ny;
		end
		if (ml > 0) begin
			r = 0;
		end else begin
			r = longint'(mag(ml)) - longint'(mag(ms));
			if (r < 0) r = 0;
			if (r > 2097151) r = 2097151;
		end
		e.ms = ms[21:0]; e.ml = ml[21:0];
		e.nx = nx[15:0]; e.ny = ny[15:0];
		e.rs = r[20:0];
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [21:0] ms, ml, logic signed [15:0] nx, ny,
			logic [20:0] rs);
		pix_res_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result ms=%0d ml=%0d", ms, ml);
			return;
		end
		e = pending.pop_front();
		if (ms !== e.ms || ml !== e.ml || nx !== e.nx || ny !== e.ny || rs !== e.rs) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch exp ms=%0d ml=%0d nx=%0d ny=%0d rs=%0d got %0d %0d %0d %0d %0d",
					e.ms, e.ml, e.nx, e.ny, e.rs, ms, ml, nx, ny, rs);
		end
	endfunction
endclass

module tb_hessian_eigen_ridge_pixel;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	logic signed [19:0] hess_xx = '0, hess_yy = '0, hess_xy = '0, grad_x = '0, grad_y = '0;
	logic busy, cfg_ready, done;
	logic signed [21:0] mu_small, mu_large;
	logic signed [15:0] normal_x, normal_y;
	logic [20:0] ridge_strength;

	ridge_scoreboard sb;
	int idle_cycles;

	localparam int LATENCY = 66;
	localparam int WATCHDOG = 20000;

	hessian_eigen_ridge_pixel dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.hess_xx(hess_xx), .hess_yy(hess_yy), .hess_xy(hess_xy),
		.grad_x(grad_x), .grad_y(grad_y), .done(done),
		.mu_small(mu_small), .mu_large(mu_large), .normal_x(normal_x),
		.normal_y(normal_y), .ridge_strength(ridge_strength)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (done) sb.check_result(mu_small, mu_large, normal_x, normal_y, ridge_strength);
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [19:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 20'sh7ffff;
			1: return 20'sh80000;
			2: return 20'sd0;
			3: return 20'($signed($urandom_range(0, 64)) - 32);
			4: return 20'($signed($urandom_range(0, 4096)) - 2048);
			default: return 20'($urandom);
		endcase
	endfunction

	task automatic wait_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pixel(logic signed [19:0] xx, yy, xy, gx, gy, bit gap);
		start <= 1'b1;
		hess_xx <= xx; hess_yy <= yy; hess_xy <= xy; grad_x <= gx; grad_y <= gy;
		do @(posedge clk); while (busy);
		sb.note_request(xx, yy, xy, gx, gy);
		if (gap) begin
			start <= 1'b0;
			wait_gap();
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_fix(bit v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.fix_normals = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(int n);
		bit burst;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) burst = $urandom_range(0, 2) == 0;
			send_pixel(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
				!burst && $urandom_range(0, 2) == 0);
		end
		drain();
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_pixel(0, 0, 0, 0, 0, 0);
		send_pixel(-5, -5, 0, 0, 0, 0);
		send_pixel(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 0);
		send_pixel(20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 0);
		send_pixel(20'sh7ffff, 20'sh80000, 20'sh80000, 0, 1, 0);
		send_pixel(20'sh80000, 20'sh7ffff, 20'sh7ffff, 1, 0, 0);
		send_pixel(100, -100, 0, -1, 0, 0);
		send_pixel(0, 0, 256, 0, -1, 0);
		send_pixel(-256, 0, 0, 3, 0, 0);
		send_pixel(256, 0, 0, 0, 0, 0);
		send_pixel(-1000, -10, 30, 5, 5, 1);
		send_pixel(7, 7, 0, -3, 2, 1);
		drain();
		write_fix(1'b0);
		send_pixel(20'sh80000, 20'sh80000, 0, 20'sh7ffff, 20'sh7ffff, 0);
		send_pixel(-1000, -10, 30, 5, 5, 0);
		send_pixel(0, 0, 256, 9, 0, 1);
		random_run(600);
		write_fix(1'b1);
		random_run(650);
		write_fix(1'b0);
		write_fix(1'b1);
		random_run(20);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

FILE: hessian_eigen_ridge_pixel.f
rtl/hrp_pkg.sv
rtl/hrp_sqrt_cell.sv
rtl/hrp_div_cell.sv
rtl/hessian_eigen_ridge_pixel.sv
tb/tb_hessian_eigen_ridge_pixel.sv
